// ===== sv/prtt_pkg.sv =====
// Shared types, codes and sizes for the pending request timeout tracker.
package prtt_pkg;

    // Table size and derived widths
    localparam int TABLE_DEPTH = 16;
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int TAG_W  = 32;
    localparam int SUB_W  = 16;
    localparam int CODE_W = 16;
    localparam int TIME_W = 32;
    localparam int KIND_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [TIME_W-1:0] TIMEOUT_RESET  = TIME_W'(3000);
    localparam logic [CODE_W-1:0] REQ_CODE_RESET = '0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_CODE = 2'd1;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_RECORD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESPONSE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SWEEP    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_IGNORE   = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_RECORDED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NOT_REQUEST = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL        = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MATCHED     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNMATCHED   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_EXPIRED     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DONE        = 3'd6;

    // One stored table entry
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SUB_W-1:0]  sub;
        logic [TIME_W-1:0] sent;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic              latch;
        logic              exec;
        logic              match_out;
        logic              sweep_rd;
        logic              done_out;
        logic [SLOT_W-1:0] sweep_idx;
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic hit;
    } t_dp_status;

endpackage

// ===== sv/prtt_ctrl.sv =====
// Controller state machine: sequences lookups, matched reads and table sweeps.
module prtt_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic [prtt_pkg::CMD_W-1:0] i_command,
    input  prtt_pkg::t_dp_status    i_status,
    output prtt_pkg::t_ctrl_cmd     o_cmd,
    output logic                    busy
);
    import prtt_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_EXEC      = 3'd1;
    localparam logic [2:0] ST_MATCH     = 3'd2;
    localparam logic [2:0] ST_SWEEP     = 3'd3;
    localparam logic [2:0] ST_SWEEP_END = 3'd4;
    localparam logic [2:0] ST_DONE      = 3'd5;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

    logic [2:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              r_is_resp, n_is_resp;
    logic              accept;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    // Next state and command decode
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_is_resp = r_is_resp;
        o_cmd     = '0;
        o_cmd.sweep_idx = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    n_is_resp   = (i_command == CMD_RESPONSE);
                    n_idx       = '0;
                    case (i_command)
                        CMD_RECORD, CMD_RESPONSE: n_state = ST_EXEC;
                        CMD_SWEEP:                n_state = ST_SWEEP;
                        default:                  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = (r_is_resp && i_status.hit) ? ST_MATCH : ST_IDLE;
            end
            ST_MATCH: begin
                o_cmd.match_out = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SWEEP: begin
                o_cmd.sweep_rd = 1'b1;
                if (r_idx == LAST_SLOT) begin
                    n_state = ST_SWEEP_END;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            // let the last slot's compare finish before done
            ST_SWEEP_END: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_cmd.done_out = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_is_resp <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_is_resp <= n_is_resp;
        end
    end

endmodule

// ===== sv/prtt_dp.sv =====
// Datapath: config registers, tag lookup, entry memory, expiry compare, result register.
module prtt_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  prtt_pkg::t_ctrl_cmd           i_cmd,
    output prtt_pkg::t_dp_status          o_status,
    input  logic                          i_cfg_we,
    input  logic [prtt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [prtt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [prtt_pkg::CMD_W-1:0]    i_command,
    input  logic [prtt_pkg::TAG_W-1:0]    i_tag,
    input  logic [prtt_pkg::SUB_W-1:0]    i_sub_command,
    input  logic [prtt_pkg::CODE_W-1:0]   i_check_code,
    input  logic [prtt_pkg::TIME_W-1:0]   i_now_ms,
    output logic                          o_valid,
    output logic [prtt_pkg::KIND_W-1:0]   o_kind,
    output logic [prtt_pkg::TAG_W-1:0]    o_out_tag,
    output logic [prtt_pkg::SUB_W-1:0]    o_out_sub_command,
    output logic                          o_last
);
    import prtt_pkg::*;

    // Configuration
    logic [TIME_W-1:0] r_timeout;
    logic [CODE_W-1:0] r_req_code;

    // Latched item
    logic [CMD_W-1:0]  r_cmd;
    logic [TAG_W-1:0]  r_tag;
    logic [SUB_W-1:0]  r_sub;
    logic [CODE_W-1:0] r_check;
    logic [TIME_W-1:0] r_now;

    // Table state
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [TAG_W-1:0]       r_cam_tag [TABLE_DEPTH];
    t_entry                 mem [TABLE_DEPTH];
    t_entry                 r_rd_data;
    logic                   r_rd_pend;
    logic [SLOT_W-1:0]      r_rd_slot;

    // Lookup
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [SLOT_W-1:0]      hit_slot, free_slot, wr_slot, rd_addr;
    logic                   hit, free_any, code_ok, wr_en, expired;
    logic [TIME_W-1:0]      elapsed;

    // Result register
    logic              r_valid_o, n_valid_o;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [TAG_W-1:0]  r_otag, n_otag;
    logic [SUB_W-1:0]  r_osub, n_osub;
    logic              r_last, n_last;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RESET;
            r_req_code <= REQ_CODE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_TIMEOUT) begin
                r_timeout <= i_cfg_data[TIME_W-1:0];
            end
            if (i_cfg_index == CFG_REQ_CODE) begin
                r_req_code <= i_cfg_data[CODE_W-1:0];
            end
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd   <= i_command;
            r_tag   <= i_tag;
            r_sub   <= i_sub_command;
            r_check <= i_check_code;
            r_now   <= i_now_ms;
        end
    end

    // Compare the item tag against every valid slot; pick lowest hit and lowest free slot
    always_comb begin
        hit_slot  = '0;
        free_slot = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            match_vec[i] = r_valid[i] && (r_cam_tag[i] == r_tag);
            if (match_vec[i]) begin
                hit_slot = SLOT_W'(i);
            end
            if (!r_valid[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign hit          = |match_vec;
    assign free_any     = ~&r_valid;
    assign code_ok      = (r_check == r_req_code);
    assign wr_en        = i_cmd.exec && (r_cmd == CMD_RECORD) && code_ok && (hit || free_any);
    assign wr_slot      = hit ? hit_slot : free_slot;
    assign rd_addr      = i_cmd.sweep_rd ? i_cmd.sweep_idx : hit_slot;
    assign o_status.hit = hit;

    // Expiry compare on the entry read in the previous cycle
    assign elapsed = r_now - r_rd_data.sent;
    assign expired = r_rd_pend && (elapsed > r_timeout);

    // Entry memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_slot] <= '{tag: r_tag, sub: r_sub, sent: r_now};
        end
        r_rd_data <= mem[rd_addr];
    end

    // Tag copies for the parallel lookup
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cam_tag[wr_slot] <= r_tag;
        end
    end

    // Set on record, drop on match or expiry
    always_comb begin
        n_valid = r_valid;
        if (wr_en) begin
            n_valid[wr_slot] = 1'b1;
        end
        if (i_cmd.exec && (r_cmd == CMD_RESPONSE) && hit) begin
            n_valid[hit_slot] = 1'b0;
        end
        if (expired) begin
            n_valid[r_rd_slot] = 1'b0;
        end
    end

    // Sweep read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_rd_pend <= i_cmd.sweep_rd && r_valid[i_cmd.sweep_idx];
        end
        r_rd_slot <= i_cmd.sweep_idx;
    end

    // Build the next result; at most one source is active in a cycle
    always_comb begin
        n_valid_o = 1'b0;
        n_kind    = KIND_DONE;
        n_otag    = '0;
        n_osub    = '0;
        n_last    = 1'b1;
        if (i_cmd.exec) begin
            n_otag = r_tag;
            if (r_cmd == CMD_RECORD) begin
                n_valid_o = 1'b1;
                if (!code_ok) begin
                    n_kind = KIND_NOT_REQUEST;
                end else if (hit || free_any) begin
                    n_kind = KIND_RECORDED;
                end else begin
                    n_kind = KIND_FULL;
                end
            end else if (!hit) begin
                n_valid_o = 1'b1;
                n_kind    = KIND_UNMATCHED;
            end
        end else if (i_cmd.match_out) begin
            n_valid_o = 1'b1;
            n_kind    = KIND_MATCHED;
            n_otag    = r_tag;
            n_osub    = r_rd_data.sub;
        end else if (expired) begin
            n_valid_o = 1'b1;
            n_kind    = KIND_EXPIRED;
            n_otag    = r_rd_data.tag;
            n_osub    = r_rd_data.sub;
            n_last    = 1'b0;
        end else if (i_cmd.done_out) begin
            n_valid_o = 1'b1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_o <= 1'b0;
        end else begin
            r_valid_o <= n_valid_o;
        end
        r_kind <= n_kind;
        r_otag <= n_otag;
        r_osub <= n_osub;
        r_last <= n_last;
    end

    assign o_valid           = r_valid_o;
    assign o_kind            = r_kind;
    assign o_out_tag         = r_otag;
    assign o_out_sub_command = r_osub;
    assign o_last            = r_last;

endmodule

// ===== sv/pending_request_timeout_tracker.sv =====
// Top level of the pending request timeout tracker: controller plus datapath.
//
//  channel   handshake                    payload
//  --------  ---------------------------  ---------------------------------------------
//  command   start, busy                  i_command i_tag i_sub_command i_check_code
//                                         i_now_ms
//  result    o_valid (one-cycle strobe)   o_kind o_out_tag o_out_sub_command o_last
//  config    i_cfg_valid, o_cfg_ready     i_cfg_index i_cfg_data
//
// Record and unmatched response: accept, then parallel tag compare; the result is registered
// from the compare state. Matched response adds a state that outputs the entry memory read.
// Sweep: accept, then one slot per cycle through the single memory read port, then end and done states.
// Reset (synchronous, active low) clears all entries and loads the register defaults.
// o_cfg_ready is always high. Results cannot be stalled: each strobe lasts one cycle.
module pending_request_timeout_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [prtt_pkg::CMD_W-1:0]        i_command,
    input  logic [prtt_pkg::TAG_W-1:0]        i_tag,
    input  logic [prtt_pkg::SUB_W-1:0]        i_sub_command,
    input  logic [prtt_pkg::CODE_W-1:0]       i_check_code,
    input  logic [prtt_pkg::TIME_W-1:0]       i_now_ms,
    output logic                              o_valid,
    output logic [prtt_pkg::KIND_W-1:0]       o_kind,
    output logic [prtt_pkg::TAG_W-1:0]        o_out_tag,
    output logic [prtt_pkg::SUB_W-1:0]        o_out_sub_command,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [prtt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [prtt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import prtt_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    prtt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_status  (dp_status),
        .o_cmd     (ctrl_cmd),
        .busy      (busy)
    );

    prtt_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (ctrl_cmd),
        .o_status          (dp_status),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_command         (i_command),
        .i_tag             (i_tag),
        .i_sub_command     (i_sub_command),
        .i_check_code      (i_check_code),
        .i_now_ms          (i_now_ms),
        .o_valid           (o_valid),
        .o_kind            (o_kind),
        .o_out_tag         (o_out_tag),
        .o_out_sub_command (o_out_sub_command),
        .o_last            (o_last)
    );

    // Only expired entries leave a result that is not the last of its item
    a_nonlast_is_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_kind == KIND_EXPIRED)
        else $error("non-final result with kind other than expired");

    // A sweep still owes its done result after any expired result
    a_expired_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_EXPIRED) |-> busy)
        else $error("expired result after sweep finished");

    // A command that does work keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_command != CMD_IGNORE) |=> busy)
        else $error("block idle right after accepting a command");

    // Sweep done carries no tag and closes the item
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_DONE) |-> (o_out_tag == '0) && o_last)
        else $error("malformed sweep done result");

endmodule

// ===== dv/pending_request_timeout_tracker_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the pending request timeout tracker.
module pending_request_timeout_tracker_test;
    import prtt_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRINT_LIMIT   = 40;

    // One command as presented on the input ports
    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [TAG_W-1:0]  tag;
        logic [SUB_W-1:0]  sub;
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] now_ms;
    } t_tracker_cmd;

    // One report as seen on the result ports
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [SUB_W-1:0]  sub;
        logic              last;
    } t_report;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic                  busy;
    logic [CMD_W-1:0]      i_command      = CMD_RECORD;
    logic [TAG_W-1:0]      i_tag          = '0;
    logic [SUB_W-1:0]      i_sub_command  = '0;
    logic [CODE_W-1:0]     i_check_code   = '0;
    logic [TIME_W-1:0]     i_now_ms       = '0;
    logic                  o_valid;
    logic [KIND_W-1:0]     o_kind;
    logic [TAG_W-1:0]      o_out_tag;
    logic [SUB_W-1:0]      o_out_sub_command;
    logic                  o_last;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = CFG_TIMEOUT;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // Mirror of the request table and registers
    logic              mirror_valid [TABLE_DEPTH] = '{default: 1'b0};
    logic [TAG_W-1:0]  mirror_tag   [TABLE_DEPTH];
    logic [SUB_W-1:0]  mirror_sub   [TABLE_DEPTH];
    logic [TIME_W-1:0] mirror_sent  [TABLE_DEPTH];
    logic [TIME_W-1:0] mirror_timeout  = TIMEOUT_RESET;
    logic [CODE_W-1:0] mirror_req_code = REQ_CODE_RESET;

    t_report           pending_reports [$];
    logic [TIME_W-1:0] clock_ms;
    int                mismatch_count = 0;
    int                cycle_count    = 0;

    pending_request_timeout_tracker u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_tag             (i_tag),
        .i_sub_command     (i_sub_command),
        .i_check_code      (i_check_code),
        .i_now_ms          (i_now_ms),
        .o_valid           (o_valid),
        .o_kind            (o_kind),
        .o_out_tag         (o_out_tag),
        .o_out_sub_command (o_out_sub_command),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic void push_report(input logic [KIND_W-1:0] kind,
                                        input logic [TAG_W-1:0] tag,
                                        input logic [SUB_W-1:0] sub,
                                        input logic last);
        t_report r;
        r.kind = kind;
        r.tag  = tag;
        r.sub  = sub;
        r.last = last;
        pending_reports.push_back(r);
    endfunction

    function automatic int find_slot(input logic [TAG_W-1:0] tag);
        foreach (mirror_valid[i]) begin
            if (mirror_valid[i] && mirror_tag[i] == tag) return i;
        end
        return -1;
    endfunction

    // Return a random occupied slot, or -1 when the table is empty
    function automatic int pick_live_slot();
        int live_n;
        int want;
        live_n = 0;
        foreach (mirror_valid[i]) begin
            if (mirror_valid[i]) live_n++;
        end
        if (live_n == 0) return -1;
        want = $urandom_range(0, live_n - 1);
        foreach (mirror_valid[i]) begin
            if (mirror_valid[i]) begin
                if (want == 0) return i;
                want--;
            end
        end
        return -1;
    endfunction

    // Update the mirror for one accepted command and queue its reports
    function automatic void apply_tracker_cmd(input t_tracker_cmd c);
        int                slot;
        logic [TIME_W-1:0] elapsed;
        slot = -1;
        case (c.command)
            CMD_RECORD: begin
                if (c.code != mirror_req_code) begin
                    push_report(KIND_NOT_REQUEST, c.tag, '0, 1'b1);
                end else begin
                    slot = find_slot(c.tag);
                    for (int i = 0; i < TABLE_DEPTH && slot < 0; i++) begin
                        if (!mirror_valid[i]) slot = i;
                    end
                    if (slot < 0) begin
                        push_report(KIND_FULL, c.tag, '0, 1'b1);
                    end else begin
                        mirror_valid[slot] = 1'b1;
                        mirror_tag[slot]   = c.tag;
                        mirror_sub[slot]   = c.sub;
                        mirror_sent[slot]  = c.now_ms;
                        push_report(KIND_RECORDED, c.tag, '0, 1'b1);
                    end
                end
            end
            CMD_RESPONSE: begin
                slot = find_slot(c.tag);
                if (slot < 0) begin
                    push_report(KIND_UNMATCHED, c.tag, '0, 1'b1);
                end else begin
                    mirror_valid[slot] = 1'b0;
                    push_report(KIND_MATCHED, c.tag, mirror_sub[slot], 1'b1);
                end
            end
            CMD_SWEEP: begin
                // Expire in slot order, wrapping elapsed time at 32 bits
                foreach (mirror_valid[i]) begin
                    elapsed = c.now_ms - mirror_sent[i];
                    if (mirror_valid[i] && elapsed > mirror_timeout) begin
                        mirror_valid[i] = 1'b0;
                        push_report(KIND_EXPIRED, mirror_tag[i], mirror_sub[i], 1'b0);
                    end
                end
                push_report(KIND_DONE, '0, '0, 1'b1);
            end
            default: begin
                // unused command code: no effect, no report
            end
        endcase
    endfunction

    // Check each result strobe against the oldest expected report
    always @(negedge i_clk) begin : result_check
        t_report wanted;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (pending_reports.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result kind %0d tag %h",
                                            o_kind, o_out_tag));
                end else begin
                    wanted = pending_reports.pop_front();
                    if (o_kind !== wanted.kind)
                        flag_mismatch($sformatf("kind %0d, want %0d", o_kind, wanted.kind));
                    if (o_out_tag !== wanted.tag)
                        flag_mismatch($sformatf("tag %h, want %h", o_out_tag, wanted.tag));
                    if (o_out_sub_command !== wanted.sub)
                        flag_mismatch($sformatf("sub_command %h, want %h",
                                                o_out_sub_command, wanted.sub));
                    if (o_last !== wanted.last)
                        flag_mismatch($sformatf("last %b, want %b", o_last, wanted.last));
                end
            end else if (o_valid !== 1'b0) begin
                flag_mismatch("result strobe unknown");
            end
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_tracker_cmd make_cmd(input logic [CMD_W-1:0] command,
                                              input logic [TAG_W-1:0] tag,
                                              input logic [SUB_W-1:0] sub,
                                              input logic [CODE_W-1:0] code,
                                              input logic [TIME_W-1:0] now_ms);
        t_tracker_cmd c;
        c.command = command;
        c.tag     = tag;
        c.sub     = sub;
        c.code    = code;
        c.now_ms  = now_ms;
        return c;
    endfunction

    // Present one command after an optional gap, hold until the transfer
    task automatic issue_cmd(input t_tracker_cmd c, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_command     <= c.command;
        i_tag         <= c.tag;
        i_sub_command <= c.sub;
        i_check_code  <= c.code;
        i_now_ms      <= c.now_ms;
        do @(negedge i_clk); while (busy !== 1'b0);
        @(posedge i_clk);
        apply_tracker_cmd(c);
    endtask

    // Stop sending and wait for every expected report
    task automatic wait_reports_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    task automatic cfg_transfer(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (o_cfg_ready !== 1'b1);
        @(posedge i_clk);
        case (idx)
            CFG_TIMEOUT:  mirror_timeout  = data[TIME_W-1:0];
            CFG_REQ_CODE: mirror_req_code = data[CODE_W-1:0];
            default: begin
            end
        endcase
    endtask

    // Reprogram both registers once the block has gone idle
    task automatic configure(input logic [TIME_W-1:0] timeout,
                             input logic [CODE_W-1:0] code);
        wait_reports_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_transfer(CFG_TIMEOUT, CFG_DATA_W'(timeout));
        cfg_transfer(CFG_REQ_CODE, CFG_DATA_W'(code));
        i_cfg_valid <= 1'b0;
    endtask

    // Record, overwrite, non-request, match, miss and unused command
    task automatic test_record_and_response();
        issue_cmd(make_cmd(CMD_RECORD, 32'h0000_0000, 16'hFFFF, mirror_req_code,
                           32'h0000_0000), idle_gap());
        issue_cmd(make_cmd(CMD_RECORD, 32'hFFFF_FFFF, 16'h0000, mirror_req_code,
                           32'hFFFF_FFFF), idle_gap());
        issue_cmd(make_cmd(CMD_RECORD, 32'h0000_0005, 16'h00A5, ~mirror_req_code,
                           32'h0000_0010), idle_gap());
        issue_cmd(make_cmd(CMD_RECORD, 32'h0000_0000, 16'h1234, mirror_req_code,
                           32'hFFFF_FFF0), idle_gap());
        issue_cmd(make_cmd(CMD_RESPONSE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                           32'h0000_0200), idle_gap());
        issue_cmd(make_cmd(CMD_RESPONSE, 32'h0000_0007, 16'h0000, 16'h0000,
                           32'h0000_0300), idle_gap());
        issue_cmd(make_cmd(CMD_IGNORE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                           32'hFFFF_FFFF), idle_gap());
    endtask

    // Elapsed time equal to the timeout keeps the entry, one more expires it
    task automatic test_sweep_expiry();
        issue_cmd(make_cmd(CMD_SWEEP, '0, '0, '0, 32'hFFFF_FFF0 + mirror_timeout),
                  idle_gap());
        issue_cmd(make_cmd(CMD_SWEEP, '0, '0, '0, 32'hFFFF_FFF1 + mirror_timeout),
                  idle_gap());
    endtask

    // Fill every slot, then one more new tag is dropped
    task automatic test_full_table();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            issue_cmd(make_cmd(CMD_RECORD, 32'hA5A5_0000 + i, SUB_W'($urandom),
                               mirror_req_code, 32'd5000 + i), idle_gap());
        end
        issue_cmd(make_cmd(CMD_RECORD, 32'h5A5A_FFFF, 16'h5A5A, mirror_req_code,
                           32'd6000), idle_gap());
    endtask

    // Mostly well-formed traffic on live tags, with noise mixed in
    task automatic run_phase(input logic [TIME_W-1:0] timeout,
                             input logic [CODE_W-1:0] code,
                             input int unsigned step_max,
                             input int n_items,
                             input bit bursty);
        t_tracker_cmd c;
        int           r;
        int           slot;
        int           gap;
        configure(timeout, code);
        for (int n = 0; n < n_items; n++) begin
            if (n == n_items / 2) wait_reports_drained();
            gap = idle_gap();
            if (bursty && (n % 40) < 15) gap = 0;

            // Advance local time, now and then jump anywhere
            if ($urandom_range(0, 99) < 90) begin
                clock_ms = clock_ms + $urandom_range(0, step_max);
            end else begin
                clock_ms = $urandom;
            end
            c = make_cmd(CMD_RECORD, $urandom, SUB_W'($urandom), mirror_req_code,
                         clock_ms);
            slot = pick_live_slot();
            r = $urandom_range(0, 99);
            if (r < 45) begin
                if (slot >= 0 && $urandom_range(0, 3) == 0) c.tag = mirror_tag[slot];
                if ($urandom_range(0, 9) == 0) c.code = CODE_W'($urandom);
            end else if (r < 78) begin
                c.command = CMD_RESPONSE;
                c.code    = CODE_W'($urandom);
                if (slot >= 0 && $urandom_range(0, 4) != 0) c.tag = mirror_tag[slot];
            end else if (r < 95) begin
                c.command = CMD_SWEEP;
                c.code    = CODE_W'($urandom);
                // Aim at the expiry boundary of a live entry
                if (slot >= 0 && $urandom_range(0, 2) == 0) begin
                    c.now_ms = mirror_sent[slot] + mirror_timeout + $urandom_range(0, 1);
                end
            end else begin
                c.command = CMD_IGNORE;
                c.code    = CODE_W'($urandom);
            end
            issue_cmd(c, gap);
        end
    endtask

    task automatic test_random_traffic();
        run_phase($urandom_range(500, 5000), CODE_W'($urandom_range(0, 16'hFFFF)), 400,
                  100, 1'b0);
        run_phase('0, 16'hFFFF, 3, 80, 1'b1);
        run_phase('1, '0, 32'hFFFF_FFFF, 80, 1'b0);
        run_phase($urandom, CODE_W'($urandom), 32'hFFFF_FFFF, 80, 1'b1);
        run_phase(32'd1, CODE_W'($urandom_range(0, 16'hFFFF)), 2, 60, 1'b0);
    endtask

    initial begin
        clock_ms = $urandom;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_record_and_response();
        test_sweep_expiry();
        test_full_table();
        test_random_traffic();

        // Let any stray results show up before judging
        wait_reports_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== pending_request_timeout_tracker.f =====
sv/prtt_pkg.sv
sv/prtt_ctrl.sv
sv/prtt_dp.sv
sv/pending_request_timeout_tracker.sv
dv/pending_request_timeout_tracker_test.sv
